// File: design/uart_text_command_decoder_defines.svh
// Assertion helpers for the text command decoder.
// Checks are compiled out when SYNTHESIS is defined.
`ifndef UART_TEXT_COMMAND_DECODER_DEFINES_SVH
`define UART_TEXT_COMMAND_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// Check that is suspended while reset is asserted.
`define UTCD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that also holds during reset.
`define UTCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define UTCD_ASSERT(lbl, clk, rst_n, prop, msg)
`define UTCD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: design/utcd_pkg.sv
package utcd_pkg;

  localparam int ByteW = 8;

  // Longest buffered command before the count wraps.
  localparam int BufferLenDefault = 20;

  // Stored head bytes: the fifth byte of a command is only ever compared live.
  localparam int HeadDepth = 4;

  localparam int IdnLen    = 10;
  localparam int SetLen    = 5;
  localparam int ReplyIdxW = $clog2(IdnLen);

  localparam logic [ByteW-1:0] CharOne  = 8'h31;
  localparam logic [ByteW-1:0] CharZero = 8'h30;

  localparam logic [4*ByteW-1:0] IdnWord = "IDN?";
  localparam logic [4*ByteW-1:0] SetWord = "SET ";
  localparam logic [3*ByteW-1:0] GetWord = "GET";

  typedef enum logic [1:0] {
    RplNone,
    RplGet,
    RplIdn,
    RplSet
  } reply_kind_e;

  // Identification string, one character per index.
  function automatic logic [ByteW-1:0] id_char(logic [ReplyIdxW-1:0] idx);
    logic [ByteW-1:0] ch;
    case (idx)
      4'd0:    ch = 8'h70;
      4'd1:    ch = 8'h69;
      4'd2:    ch = 8'h63;
      4'd3:    ch = 8'h31;
      4'd4:    ch = 8'h36;
      4'd5:    ch = 8'h66;
      4'd6:    ch = 8'h38;
      4'd7:    ch = 8'h37;
      4'd8:    ch = 8'h37;
      4'd9:    ch = 8'h61;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Byte k of a four-character word, first character at k = 0.
  function automatic logic [ByteW-1:0] word4_char(logic [4*ByteW-1:0] word,
                                                  logic [1:0] k);
    logic [ByteW-1:0] ch;
    case (k)
      2'd0:    ch = word[4*ByteW-1 -: ByteW];
      2'd1:    ch = word[3*ByteW-1 -: ByteW];
      2'd2:    ch = word[2*ByteW-1 -: ByteW];
      default: ch = word[ByteW-1 -: ByteW];
    endcase
    return ch;
  endfunction

endpackage

// File: design/utcd_channels.sv
// Received byte channel.
interface utcd_rx_if;
  logic                       valid;
  logic                       ready;
  logic [utcd_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Reply byte channel.
interface utcd_tx_if;
  logic                       valid;
  logic                       ready;
  logic [utcd_pkg::ByteW-1:0] response_byte;
  logic                       last;
  logic                       pin_level;

  modport source (output valid, output response_byte, output last, output pin_level,
                  input ready);
  modport sink   (input valid, input response_byte, input last, input pin_level,
                  output ready);
endinterface

// File: design/uart_text_command_decoder.sv
// Text command decoder for a received serial byte stream.
//
// rx_i (sink): one received character per item. tx_o (source): reply
// characters, one per item, with last on the final character and pin_level
// giving the controlled pin after the command.
//
// Commands are matched at fixed byte counts: "GET" (3 bytes) replies '1' or
// '0', "IDN?" (4 bytes) replies the 10-character id string, "SET 1"/"SET 0"
// (5 bytes) drives the pin and echoes the command. There is no resync on
// mismatch; the count wraps at BUFFER_LEN bytes with no reply.
//
// A byte that ends no command is taken every cycle while no reply is
// pending. A byte that completes a command starts an n-byte reply (n = 1,
// 10 or 5); the reply sequencer then holds rx_i.ready low until it has fed
// its last byte to the output register, one byte per cycle while tx_o is not
// stalled; a reply passes the sequencer state, then that register. A stalled
// tx_o holds the output register and the sequencer with it, so input is held
// off only while reply bytes are still pending. Reset clears the count, the
// pin (low) and any pending reply; the stored head bytes are not cleared.

`include "uart_text_command_decoder_defines.svh"

module uart_text_command_decoder #(
  parameter int BUFFER_LEN = utcd_pkg::BufferLenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  utcd_rx_if.sink     rx_i,
  utcd_tx_if.source   tx_o
);

  localparam int CountW = $clog2(BUFFER_LEN + 1);
  localparam int ByteW  = utcd_pkg::ByteW;
  localparam int IdxW   = utcd_pkg::ReplyIdxW;

  // Command state
  logic [CountW-1:0] count_q, count_d;
  logic [ByteW-1:0]  head_q [utcd_pkg::HeadDepth];
  logic              pin_q, pin_d;

  // Reply sequencer
  utcd_pkg::reply_kind_e kind_q, kind_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [ByteW-1:0]      set_char_q;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  out_byte_q;
  logic              out_last_q;
  logic              out_pin_q;

  logic              busy;
  logic              accept;
  logic [CountW-1:0] count_inc;
  logic [ByteW-1:0]  c;
  logic              idn_hit, set_hit, set_ok, get_hit;
  logic              load;
  logic [ByteW-1:0]  seq_byte;
  logic              seq_last;

  assign busy      = (kind_q != utcd_pkg::RplNone);
  assign accept    = rx_i.valid && !busy;
  assign c         = rx_i.rx_byte;
  assign count_inc = count_q + CountW'(1);

  // Matches against the stored head plus the byte now arriving.
  assign idn_hit = (count_inc == CountW'(4))
                && (head_q[0] == utcd_pkg::word4_char(utcd_pkg::IdnWord, 2'd0))
                && (head_q[1] == utcd_pkg::word4_char(utcd_pkg::IdnWord, 2'd1))
                && (head_q[2] == utcd_pkg::word4_char(utcd_pkg::IdnWord, 2'd2))
                && (c         == utcd_pkg::word4_char(utcd_pkg::IdnWord, 2'd3));

  assign set_hit = (count_inc == CountW'(5))
                && (head_q[0] == utcd_pkg::word4_char(utcd_pkg::SetWord, 2'd0))
                && (head_q[1] == utcd_pkg::word4_char(utcd_pkg::SetWord, 2'd1))
                && (head_q[2] == utcd_pkg::word4_char(utcd_pkg::SetWord, 2'd2))
                && (head_q[3] == utcd_pkg::word4_char(utcd_pkg::SetWord, 2'd3));

  assign set_ok  = set_hit && ((c == utcd_pkg::CharOne) || (c == utcd_pkg::CharZero));

  assign get_hit = (count_inc == CountW'(3))
                && (head_q[0] == utcd_pkg::GetWord[3*ByteW-1 -: ByteW])
                && (head_q[1] == utcd_pkg::GetWord[2*ByteW-1 -: ByteW])
                && (c         == utcd_pkg::GetWord[ByteW-1 -: ByteW]);

  // Current reply byte from the sequencer.
  always_comb begin
    seq_byte = '0;
    seq_last = 1'b0;
    unique case (kind_q)
      utcd_pkg::RplGet: begin
        seq_byte = pin_q ? utcd_pkg::CharOne : utcd_pkg::CharZero;
        seq_last = 1'b1;
      end
      utcd_pkg::RplIdn: begin
        seq_byte = utcd_pkg::id_char(idx_q);
        seq_last = (idx_q == IdxW'(utcd_pkg::IdnLen - 1));
      end
      utcd_pkg::RplSet: begin
        seq_byte = (idx_q == IdxW'(utcd_pkg::SetLen - 1)) ? set_char_q
                 : utcd_pkg::word4_char(utcd_pkg::SetWord, idx_q[1:0]);
        seq_last = (idx_q == IdxW'(utcd_pkg::SetLen - 1));
      end
      default: begin
        seq_byte = '0;
        seq_last = 1'b0;
      end
    endcase
  end

  // A reply byte moves into the output register whenever that is free.
  assign load = busy && (!out_valid_q || tx_o.ready);

  always_comb begin
    count_d     = count_q;
    pin_d       = pin_q;
    kind_d      = kind_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;

    if (tx_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (load) begin
      out_valid_d = 1'b1;
      if (seq_last) begin
        kind_d = utcd_pkg::RplNone;
        idx_d  = '0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end

    if (accept) begin
      idx_d = '0;
      if (idn_hit) begin
        count_d = '0;
        kind_d  = utcd_pkg::RplIdn;
      end else if (set_hit) begin
        // Any other fifth byte drops the command silently.
        count_d = '0;
        if (set_ok) begin
          pin_d  = (c == utcd_pkg::CharOne);
          kind_d = utcd_pkg::RplSet;
        end
      end else if (get_hit) begin
        count_d = '0;
        kind_d  = utcd_pkg::RplGet;
      end else if (count_inc >= CountW'(BUFFER_LEN)) begin
        count_d = '0;
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pin_q       <= 1'b0;
      kind_q      <= utcd_pkg::RplNone;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pin_q       <= pin_d;
      kind_q      <= kind_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (accept && (count_q < CountW'(utcd_pkg::HeadDepth))) begin
      head_q[count_q[1:0]] <= c;
    end
    if (accept) begin
      set_char_q <= c;
    end
    if (load) begin
      out_byte_q <= seq_byte;
      out_last_q <= seq_last;
      out_pin_q  <= pin_q;
    end
  end

  assign rx_i.ready         = !busy;
  assign tx_o.valid         = out_valid_q;
  assign tx_o.response_byte = out_byte_q;
  assign tx_o.last          = out_last_q;
  assign tx_o.pin_level     = out_pin_q;

  // A reply only starts once the command count has cleared.
  `UTCD_ASSERT(a_busy_count_clear, clk_i, rst_ni, busy |-> (count_q == '0), "reply with count set")
  // The count wraps before it can reach the buffer length.
  `UTCD_ASSERT(a_count_bound, clk_i, rst_ni, count_q < CountW'(BUFFER_LEN), "count out of range")
  // A shown byte that is not last means the sequencer still owes the rest.
  `UTCD_ASSERT(a_reply_pending, clk_i, rst_ni, (out_valid_q && !out_last_q) |-> busy, "reply cut")
  // Nothing is offered on the output while reset is held.
  `UTCD_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !tx_o.valid, "output valid in reset")

endmodule
